### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/tlca_pkg.sv
// Types and constants shared by the LCA core.
`default_nettype none
package tlca_pkg;

	localparam int FW = 10;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]    command;
		logic [FW-1:0] node_a;
		logic [FW-1:0] node_b;
		logic [FW-1:0] node_depth;
	} in_word_t;

	typedef struct packed {
		logic [FW-1:0] ancestor;
	} out_word_t;

	typedef logic [1:0] anc_sel_t;
	localparam anc_sel_t ASEL_BLD_J = 2'd0;
	localparam anc_sel_t ASEL_BLD_P = 2'd1;
	localparam anc_sel_t ASEL_U     = 2'd2;
	localparam anc_sel_t ASEL_V     = 2'd3;

	typedef struct packed {
		logic     load_wr;
		logic     build_start;
		logic     build_wr;
		logic     j_step;
		anc_sel_t anc_sel;
		logic     dep_sel_v;
		logic     latch_query;
		logic     cap_du;
		logic     swap;
		logic     lv_top;
		logic     lv_dec;
		logic     lift_v;
		logic     cap_au;
		logic     sel_cmp;
		logic     res_u;
		logic     res_final;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic lv_zero;
		logic lv_last;
		logic j_last;
		logic diff_bit;
		logic u_eq_v;
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

### rtl/core/tlca_chan_if.sv
// Valid/ready channel carrying one word of type T.
`default_nettype none
interface tlca_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/tlca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlca_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/tlca_ctrl.sv
// Controller state machine for load, build and query sequencing.
`default_nettype none
`include "assert_macros.svh"
module tlca_ctrl import tlca_pkg::*; #(
	parameter int LEVELS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_command,
	output logic            in_ready,
	input  wire ctl_sts_t   sts,
	output ctl_cmd_t        cmd
);
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_B_RD1  = 4'd1;
	localparam logic [3:0] ST_B_RD2  = 4'd2;
	localparam logic [3:0] ST_B_WR   = 4'd3;
	localparam logic [3:0] ST_Q_D1   = 4'd4;
	localparam logic [3:0] ST_Q_D2   = 4'd5;
	localparam logic [3:0] ST_Q_D3   = 4'd6;
	localparam logic [3:0] ST_LIFT   = 4'd7;
	localparam logic [3:0] ST_LIFTW  = 4'd8;
	localparam logic [3:0] ST_EQ     = 4'd9;
	localparam logic [3:0] ST_S1     = 4'd10;
	localparam logic [3:0] ST_S2     = 4'd11;
	localparam logic [3:0] ST_S3     = 4'd12;
	localparam logic [3:0] ST_F      = 4'd13;
	localparam logic [3:0] ST_FW     = 4'd14;
	localparam logic [3:0] ST_OUT    = 4'd15;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.anc_sel = ASEL_U;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_command)
						CMD_LOAD: begin
							cmd.load_wr = 1'b1;
						end
						CMD_BUILD: begin
							if (LEVELS > 1) begin
								cmd.build_start = 1'b1;
								state_d = ST_B_RD1;
							end
						end
						CMD_QUERY: begin
							cmd.latch_query = 1'b1;
							state_d = ST_Q_D1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_B_RD1: begin
				cmd.anc_sel = ASEL_BLD_J;
				state_d = ST_B_RD2;
			end
			ST_B_RD2: begin
				cmd.anc_sel = ASEL_BLD_P;
				state_d = ST_B_WR;
			end
			ST_B_WR: begin
				cmd.build_wr = 1'b1;
				cmd.j_step = 1'b1;
				state_d = (sts.j_last && sts.lv_last) ? ST_IDLE : ST_B_RD1;
			end
			ST_Q_D1: begin
				state_d = ST_Q_D2;
			end
			ST_Q_D2: begin
				cmd.cap_du = 1'b1;
				cmd.dep_sel_v = 1'b1;
				state_d = ST_Q_D3;
			end
			ST_Q_D3: begin
				cmd.swap = 1'b1;
				cmd.lv_top = 1'b1;
				state_d = ST_LIFT;
			end
			ST_LIFT: begin
				cmd.anc_sel = ASEL_V;
				if (sts.diff_bit) begin
					state_d = ST_LIFTW;
				end else if (sts.lv_zero) begin
					state_d = ST_EQ;
				end else begin
					cmd.lv_dec = 1'b1;
				end
			end
			ST_LIFTW: begin
				cmd.lift_v = 1'b1;
				if (sts.lv_zero) begin
					state_d = ST_EQ;
				end else begin
					cmd.lv_dec = 1'b1;
					state_d = ST_LIFT;
				end
			end
			ST_EQ: begin
				if (sts.u_eq_v) begin
					cmd.res_u = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.lv_top = 1'b1;
					state_d = ST_S1;
				end
			end
			ST_S1: begin
				cmd.anc_sel = ASEL_U;
				state_d = ST_S2;
			end
			ST_S2: begin
				cmd.cap_au = 1'b1;
				cmd.anc_sel = ASEL_V;
				state_d = ST_S3;
			end
			ST_S3: begin
				cmd.sel_cmp = 1'b1;
				if (sts.lv_zero) begin
					state_d = ST_F;
				end else begin
					cmd.lv_dec = 1'b1;
					state_d = ST_S1;
				end
			end
			ST_F: begin
				cmd.anc_sel = ASEL_U;
				state_d = ST_FW;
			end
			ST_FW: begin
				cmd.res_final = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_IMPL(a_one_writer, clk, arst_n, cmd.load_wr, !cmd.build_wr)
	`ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && (in_command == CMD_QUERY), !in_ready)
endmodule
`default_nettype wire

### rtl/core/tlca_dp.sv
// Datapath: parent/depth stores, ancestor table, query registers, result register.
`default_nettype none
`include "assert_macros.svh"
module tlca_dp import tlca_pkg::*; #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	output ctl_sts_t      sts,
	input  wire in_word_t in_word,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_word
);
	localparam int NW = $clog2(NODES);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AW = $clog2(LEVELS * NODES);

	// node number modulo NODES by descending compare/subtract
	function automatic logic [NW-1:0] node_idx(input logic [FW-1:0] x);
		logic [FW-1:0] r;
		r = x;
		for (int k = FW - 1; k >= 0; k--) begin
			if ((NODES << k) < (1 << FW)) begin
				if (r >= FW'(NODES << k)) begin
					r = r - FW'(NODES << k);
				end
			end
		end
		return NW'(r);
	endfunction

	function automatic logic [AW-1:0] anc_addr(input logic [LW-1:0] l, input logic [NW-1:0] n);
		return AW'(l) * AW'(NODES) + AW'(n);
	endfunction

	logic [NW-1:0] u_q, v_q, au_q, j_q, res_q;
	logic [FW-1:0] du_q, diff_q, dsh;
	logic [LW-1:0] lv_q, lv_m1;
	logic          out_valid_q;
	logic [FW-1:0] out_data_q;

	logic [AW-1:0] anc_waddr, anc_raddr;
	logic [FW-1:0] anc_wdata, anc_rdata, dep_rdata;
	logic [NW-1:0] anc_node, in_a_idx;
	logic          anc_we;

	assign anc_node = node_idx(anc_rdata);
	assign in_a_idx = node_idx(in_word.node_a);
	assign lv_m1    = lv_q - LW'(1);

	always_comb begin
		case (cmd.anc_sel)
			ASEL_BLD_J: anc_raddr = anc_addr(lv_m1, j_q);
			ASEL_BLD_P: anc_raddr = anc_addr(lv_m1, anc_node);
			ASEL_U:     anc_raddr = anc_addr(lv_q, u_q);
			default:    anc_raddr = anc_addr(lv_q, v_q);
		endcase
	end

	assign anc_we    = cmd.load_wr || cmd.build_wr;
	assign anc_waddr = cmd.load_wr ? anc_addr('0, in_a_idx) : anc_addr(lv_q, j_q);
	assign anc_wdata = cmd.load_wr ? in_word.node_b : anc_rdata;

	tlca_ram #(.WIDTH(FW), .DEPTH(LEVELS * NODES)) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_waddr),
		.wdata (anc_wdata),
		.raddr (anc_raddr),
		.rdata (anc_rdata)
	);

	tlca_ram #(.WIDTH(FW), .DEPTH(NODES)) u_dep_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (in_a_idx),
		.wdata (in_word.node_depth),
		.raddr (cmd.dep_sel_v ? v_q : u_q),
		.rdata (dep_rdata)
	);

	// bit lv_q of the difference lands in bit 0; a shift at or above the field width leaves zero
	assign dsh = diff_q >> lv_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_query) begin
			u_q <= node_idx(in_word.node_a);
			v_q <= node_idx(in_word.node_b);
		end
		if (cmd.cap_du) begin
			du_q <= dep_rdata;
		end
		if (cmd.swap) begin
			if (du_q > dep_rdata) begin
				u_q    <= v_q;
				v_q    <= u_q;
				diff_q <= du_q - dep_rdata;
			end else begin
				diff_q <= dep_rdata - du_q;
			end
		end
		if (cmd.lift_v) begin
			v_q <= anc_node;
		end
		if (cmd.cap_au) begin
			au_q <= anc_node;
		end
		if (cmd.sel_cmp && (au_q != anc_node)) begin
			u_q <= au_q;
			v_q <= anc_node;
		end
		if (cmd.res_u) begin
			res_q <= u_q;
		end
		if (cmd.res_final) begin
			res_q <= anc_node;
		end
		if (cmd.build_start) begin
			lv_q <= LW'(1);
			j_q  <= '0;
		end else if (cmd.j_step) begin
			if (j_q == NW'(NODES - 1)) begin
				j_q  <= '0;
				lv_q <= lv_q + LW'(1);
			end else begin
				j_q <= j_q + NW'(1);
			end
		end else if (cmd.lv_top) begin
			lv_q <= LW'(LEVELS - 1);
		end else if (cmd.lv_dec) begin
			lv_q <= lv_m1;
		end
		if (cmd.out_load) begin
			out_data_q <= FW'(res_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_word.ancestor = out_data_q;

	assign sts.lv_zero  = (lv_q == '0);
	assign sts.lv_last  = (lv_q == LW'(LEVELS - 1));
	assign sts.j_last   = (j_q == NW'(NODES - 1));
	assign sts.diff_bit = dsh[0];
	assign sts.u_eq_v   = (u_q == v_q);
	assign sts.out_free = !out_valid_q || out_ready;

	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.out_load, sts.out_free)
	`ASSERT_IMPL(a_valid_source, clk, arst_n, $rose(out_valid_q), $past(cmd.out_load))
endmodule
`default_nettype wire

### rtl/core/tree_lca_binary_lifting_core.sv
// Top level of the lowest-common-ancestor core (binary lifting).
// Keeps a parent and a depth per node plus a LEVELS x NODES ancestor table in
// single-port-read RAMs. A load word (command 0) writes node_a's parent node_b
// and depth node_depth in the accept cycle and is ready again at once. A build
// word (command 1) fills levels 1..LEVELS-1 of the table: per entry it reads
// node j's entry a level down, then that node's entry, and writes it. A query
// word (command 2) returns one word on result: two depth reads, a lift over
// LEVELS levels, a descending search unless the lifted nodes already match,
// and a final parent read, kept serial by the one read port of the ancestor
// RAM. Node numbers at or above NODES are taken modulo NODES. Results wait in
// an output register, so a new word is taken while one is still pending.
// Stores are not cleared at reset; query only nodes that were loaded.
`default_nettype none
module tree_lca_binary_lifting_core import tlca_pkg::*; #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input wire logic     clk,
	input wire logic     arst_n,
	tlca_chan_if.sink    request,
	tlca_chan_if.source  result
);
	ctl_cmd_t  cmd;
	ctl_sts_t  sts;
	in_word_t  in_word;
	out_word_t out_word;

	assign in_word     = request.data;
	assign result.data = out_word;

	// sequencer
	tlca_ctrl #(.LEVELS(LEVELS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_command (in_word.command),
		.in_ready   (request.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// stores, table walk registers and the result register
	tlca_dp #(.NODES(NODES), .LEVELS(LEVELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_word  (out_word)
	);
endmodule
`default_nettype wire
